### rtl/core/sit_pkg.sv
// sit_pkg: shared types and constants of the segment intersection test.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sit_pkg;

    // Width of every coordinate port; only the low COORD_WIDTH bits are used.
    localparam int FIELD_WIDTH = 32;

    // Bit positions in t_rel.on_box: which point lies in which bounding box.
    localparam int BOX_Q0_IN_P = 0;
    localparam int BOX_Q1_IN_P = 1;
    localparam int BOX_P0_IN_Q = 2;
    localparam int BOX_P1_IN_Q = 3;
    localparam int BOX_COUNT   = 4;

    // Orientation sign: positive is neg = 0 and zero = 0.
    typedef struct packed {
        logic neg;
        logic zero;
    } t_orient;

    // Endpoint relations and bounding box hits of one segment pair.
    typedef struct packed {
        logic                 degen;
        logic                 same_seg;
        logic                 shared_end;
        logic [BOX_COUNT-1:0] on_box;
    } t_rel;

endpackage

### rtl/core/sit_orient.sv
// sit_orient: exact orientation sign of three points, one register stage deep.
// Depends on sit_pkg (t_orient).
`timescale 1ns / 1ps

module sit_orient #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_ax,
    input  logic signed [W-1:0]   i_ay,
    input  logic signed [W-1:0]   i_bx,
    input  logic signed [W-1:0]   i_by,
    input  logic signed [W-1:0]   i_cx,
    input  logic signed [W-1:0]   i_cy,
    output sit_pkg::t_orient      o_orient
);
    import sit_pkg::*;

    localparam int DW = W + 1;       // coordinate difference
    localparam int PW = 2 * DW;      // exact product
    localparam int SW = PW + 1;      // difference of products

    logic signed [DW-1:0] w_dy_ab;
    logic signed [DW-1:0] w_dx_bc;
    logic signed [DW-1:0] w_dx_ab;
    logic signed [DW-1:0] w_dy_bc;
    logic signed [PW-1:0] r_prod_p;
    logic signed [PW-1:0] r_prod_q;
    logic signed [SW-1:0] w_det;

    assign w_dy_ab = $signed({i_by[W-1], i_by}) - $signed({i_ay[W-1], i_ay});
    assign w_dx_bc = $signed({i_cx[W-1], i_cx}) - $signed({i_bx[W-1], i_bx});
    assign w_dx_ab = $signed({i_bx[W-1], i_bx}) - $signed({i_ax[W-1], i_ax});
    assign w_dy_bc = $signed({i_cy[W-1], i_cy}) - $signed({i_by[W-1], i_by});

    // products registered before the subtract
    always_ff @(posedge i_clk) begin
        r_prod_p <= w_dy_ab * w_dx_bc;
        r_prod_q <= w_dx_ab * w_dy_bc;
    end

    assign w_det = $signed({r_prod_p[PW-1], r_prod_p})
                 - $signed({r_prod_q[PW-1], r_prod_q});

    assign o_orient.neg  = w_det[SW-1];
    assign o_orient.zero = (r_prod_p == r_prod_q);

endmodule

### rtl/core/sit_relate.sv
// sit_relate: endpoint equality and bounding box checks, one register stage.
// Depends on sit_pkg (t_rel, box bit positions).
`timescale 1ns / 1ps

module sit_relate #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_p0x,
    input  logic signed [W-1:0]   i_p0y,
    input  logic signed [W-1:0]   i_p1x,
    input  logic signed [W-1:0]   i_p1y,
    input  logic signed [W-1:0]   i_q0x,
    input  logic signed [W-1:0]   i_q0y,
    input  logic signed [W-1:0]   i_q1x,
    input  logic signed [W-1:0]   i_q1y,
    output sit_pkg::t_rel         o_rel
);
    import sit_pkg::*;

    t_rel n_rel;
    t_rel r_rel;

    // b inside the box spanned by a and c
    function automatic logic in_box(
        input logic signed [W-1:0] ax, input logic signed [W-1:0] ay,
        input logic signed [W-1:0] bx, input logic signed [W-1:0] by,
        input logic signed [W-1:0] cx, input logic signed [W-1:0] cy
    );
        logic x_ok;
        logic y_ok;
        x_ok = (ax < cx) ? (bx >= ax && bx <= cx) : (bx >= cx && bx <= ax);
        y_ok = (ay < cy) ? (by >= ay && by <= cy) : (by >= cy && by <= ay);
        return x_ok && y_ok;
    endfunction

    logic w_p0_p1, w_q0_q1, w_p0_q0, w_p1_q1, w_p0_q1, w_p1_q0;

    assign w_p0_p1 = (i_p0x == i_p1x) && (i_p0y == i_p1y);
    assign w_q0_q1 = (i_q0x == i_q1x) && (i_q0y == i_q1y);
    assign w_p0_q0 = (i_p0x == i_q0x) && (i_p0y == i_q0y);
    assign w_p1_q1 = (i_p1x == i_q1x) && (i_p1y == i_q1y);
    assign w_p0_q1 = (i_p0x == i_q1x) && (i_p0y == i_q1y);
    assign w_p1_q0 = (i_p1x == i_q0x) && (i_p1y == i_q0y);

    always_comb begin
        n_rel.degen      = w_p0_p1 || w_q0_q1;
        n_rel.same_seg   = (w_p0_q0 && w_p1_q1) || (w_p0_q1 && w_p1_q0);
        n_rel.shared_end = w_p0_q0 || w_p1_q1 || w_p0_q1 || w_p1_q0;
        n_rel.on_box[BOX_Q0_IN_P] = in_box(i_p0x, i_p0y, i_q0x, i_q0y, i_p1x, i_p1y);
        n_rel.on_box[BOX_Q1_IN_P] = in_box(i_p0x, i_p0y, i_q1x, i_q1y, i_p1x, i_p1y);
        n_rel.on_box[BOX_P0_IN_Q] = in_box(i_q0x, i_q0y, i_p0x, i_p0y, i_q1x, i_q1y);
        n_rel.on_box[BOX_P1_IN_Q] = in_box(i_q0x, i_q0y, i_p1x, i_p1y, i_q1x, i_q1y);
    end

    always_ff @(posedge i_clk) begin
        r_rel <= n_rel;
    end

    assign o_rel = r_rel;

endmodule

### rtl/core/segment_intersection_test.sv
// segment_intersection_test: top level, decides whether two 2D segments meet.
// Depends on sit_pkg, sit_orient and sit_relate.
`timescale 1ns / 1ps
//
//  channel   direction  ports                                     transfer when
//  -------   ---------  ----------------------------------------  -----------------------
//  command   in         start, busy, i_first_*, i_second_*        start && !busy at edge
//  result    out        o_done, o_crossing                        o_done high (one cycle)
//
//  One segment pair per cycle, sustained while busy is low. On accept the
//  input register is loaded; the eight cross products and the endpoint/box
//  flags are registered from it, then o_crossing and o_done from those. The
//  depth is set by the 33x33 product multipliers, which are registered before
//  the wide subtract. Synchronous active-low reset clears the valid chain; busy
//  is high during reset and until an edge with reset released sets r_ready, low
//  from then on. The receiver cannot stall, so nothing ever backs up.

module segment_intersection_test #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [sit_pkg::FIELD_WIDTH-1:0]  i_first_start_x,
    input  logic signed [sit_pkg::FIELD_WIDTH-1:0]  i_first_start_y,
    input  logic signed [sit_pkg::FIELD_WIDTH-1:0]  i_first_end_x,
    input  logic signed [sit_pkg::FIELD_WIDTH-1:0]  i_first_end_y,
    input  logic signed [sit_pkg::FIELD_WIDTH-1:0]  i_second_start_x,
    input  logic signed [sit_pkg::FIELD_WIDTH-1:0]  i_second_start_y,
    input  logic signed [sit_pkg::FIELD_WIDTH-1:0]  i_second_end_x,
    input  logic signed [sit_pkg::FIELD_WIDTH-1:0]  i_second_end_y,
    output logic                                    o_done,
    output logic                                    o_crossing
);
    import sit_pkg::*;

    localparam int W = COORD_WIDTH;

    // --- control: ready flag and valid chain -------------------------------
    logic r_ready;
    logic r_vld_a;      // input register holds an item
    logic r_vld_b;      // products / flags hold an item
    logic r_done;
    logic w_accept;

    assign busy     = !r_ready;
    assign w_accept = start && r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_vld_a <= w_accept;
            r_vld_b <= r_vld_a;
            r_done  <= r_vld_b;
        end
    end

    // --- input register: low W bits of each coordinate, taken as signed ----
    logic signed [W-1:0] r_p0x, r_p0y, r_p1x, r_p1y;
    logic signed [W-1:0] r_q0x, r_q0y, r_q1x, r_q1y;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p0x <= i_first_start_x[W-1:0];
            r_p0y <= i_first_start_y[W-1:0];
            r_p1x <= i_first_end_x[W-1:0];
            r_p1y <= i_first_end_y[W-1:0];
            r_q0x <= i_second_start_x[W-1:0];
            r_q0y <= i_second_start_y[W-1:0];
            r_q1x <= i_second_end_x[W-1:0];
            r_q1y <= i_second_end_y[W-1:0];
        end
    end

    // --- four orientation tests --------------------------------------------
    // o1 = orient(p0,p1,q0), o2 = orient(p0,p1,q1)
    // o3 = orient(q0,q1,p0), o4 = orient(q0,q1,p1)
    t_orient w_o1, w_o2, w_o3, w_o4;

    sit_orient #(.W(W)) u_orient_1 (
        .i_clk(i_clk),
        .i_ax(r_p0x), .i_ay(r_p0y), .i_bx(r_p1x), .i_by(r_p1y),
        .i_cx(r_q0x), .i_cy(r_q0y), .o_orient(w_o1)
    );
    sit_orient #(.W(W)) u_orient_2 (
        .i_clk(i_clk),
        .i_ax(r_p0x), .i_ay(r_p0y), .i_bx(r_p1x), .i_by(r_p1y),
        .i_cx(r_q1x), .i_cy(r_q1y), .o_orient(w_o2)
    );
    sit_orient #(.W(W)) u_orient_3 (
        .i_clk(i_clk),
        .i_ax(r_q0x), .i_ay(r_q0y), .i_bx(r_q1x), .i_by(r_q1y),
        .i_cx(r_p0x), .i_cy(r_p0y), .o_orient(w_o3)
    );
    sit_orient #(.W(W)) u_orient_4 (
        .i_clk(i_clk),
        .i_ax(r_q0x), .i_ay(r_q0y), .i_bx(r_q1x), .i_by(r_q1y),
        .i_cx(r_p1x), .i_cy(r_p1y), .o_orient(w_o4)
    );

    // --- endpoint relations and box checks ---------------------------------
    t_rel w_rel;

    sit_relate #(.W(W)) u_relate (
        .i_clk(i_clk),
        .i_p0x(r_p0x), .i_p0y(r_p0y), .i_p1x(r_p1x), .i_p1y(r_p1y),
        .i_q0x(r_q0x), .i_q0y(r_q0y), .i_q1x(r_q1x), .i_q1y(r_q1y),
        .o_rel(w_rel)
    );

    // --- decision ----------------------------------------------------------
    // Priority: degenerate -> no, same segment (either direction) -> yes,
    // any other shared endpoint -> no, then proper crossing or collinear touch.
    logic n_crossing;
    logic r_crossing;
    logic w_proper;
    logic w_touch;

    assign w_proper = (w_o1 != w_o2) && (w_o3 != w_o4);
    assign w_touch  = (w_o1.zero && w_rel.on_box[BOX_Q0_IN_P])
                   || (w_o2.zero && w_rel.on_box[BOX_Q1_IN_P])
                   || (w_o3.zero && w_rel.on_box[BOX_P0_IN_Q])
                   || (w_o4.zero && w_rel.on_box[BOX_P1_IN_Q]);

    always_comb begin
        if (w_rel.degen) begin
            n_crossing = 1'b0;
        end else if (w_rel.same_seg) begin
            n_crossing = 1'b1;
        end else if (w_rel.shared_end) begin
            n_crossing = 1'b0;
        end else begin
            n_crossing = w_proper || w_touch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crossing <= n_crossing;
    end

    assign o_done     = r_done;
    assign o_crossing = r_crossing;

    // --- checks ------------------------------------------------------------
    // every accepted item raises o_done after passing the input, product/flag and output registers
    a_accept_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##3 o_done)
        else $error("accepted item produced no result");

    // no result strobe without an earlier accepted item
    a_done_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, 3))
        else $error("result strobe without an accepted item");

    // a degenerate segment never reports a crossing
    a_degen_no_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_b && w_rel.degen) |=> (o_done && !o_crossing))
        else $error("degenerate segment reported as crossing");

    // identical or reversed non-degenerate segments always cross
    a_same_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_b && !w_rel.degen && w_rel.same_seg) |=> (o_done && o_crossing))
        else $error("identical segments not reported as crossing");

    // shared endpoint of distinct segments never crosses
    a_shared_no_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_b && w_rel.shared_end && !w_rel.same_seg) |=> !o_crossing)
        else $error("segments sharing only an endpoint reported as crossing");

endmodule
